[rtl/ssrp_pkg.sv]
// Shared types, constants and per-joint tables for the servo slew ramp pulse mapper.
package ssrp_pkg;

    localparam int JOINTS      = 7;
    localparam int JOINT_IDX_W = 4;
    localparam int KIND_W      = 2;
    localparam int TARGET_W    = 28;
    localparam int ELAPSED_W   = 16;
    localparam int ANGLE_W     = 32;
    localparam int PULSE_W     = 15;
    localparam int INV_W       = 16;
    localparam int MAXSPD_W    = 31;
    localparam int SHIFT_W     = 26;
    localparam int GAIN_W      = 26;
    localparam int NUDGE_W     = 7;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOME = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_INVERSE_PERIOD = 1'b0;
    localparam logic REG_MAX_SPEED      = 1'b1;

    localparam logic [INV_W-1:0]    INV_PERIOD_RST = 16'd3277;
    localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST  = 31'd6746518;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 32'sd26353589;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN   = 32'sh80000000;

    // ceil(2^43 / 125): exact floor division by 125 for 36-bit dividends
    localparam logic [36:0] RECIP_125 = 37'd70368744178;

    localparam logic [PULSE_W-1:0] PULSE_MAX  = 15'd19999;
    localparam logic [9:0]         PULSE_BASE = 10'd500;

    typedef struct packed {
        logic [INV_W-1:0]    inverse_period;
        logic [MAXSPD_W-1:0] max_speed;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] home;
        logic [SHIFT_W-1:0] shift;
        logic [GAIN_W-1:0]  gain;
        logic [NUDGE_W-1:0] nudge;
    } lane_const_t;

    typedef struct packed {
        logic                 start;
        logic [KIND_W-1:0]    kind;
        logic [TARGET_W-1:0]  target;
        logic [ELAPSED_W-1:0] elapsed;
    } lane_cmd_t;

    typedef struct packed {
        logic               done;
        logic [PULSE_W-1:0] pulse;
    } lane_stat_t;

    function automatic lane_const_t lane_const_of(input logic [JOINT_IDX_W-1:0] j);
        lane_const_t c;
        c.home  = 32'd0;
        c.shift = 26'(HALF_PI_Q24);
        c.gain  = 26'd41721513;
        c.nudge = 7'd0;
        unique case (j)
            4'd0:
            begin
                c.shift = 26'd0;
                c.gain  = 26'd28381982;
            end
            4'd1:
            begin
                c.home  = HALF_PI_Q24;
                c.shift = 26'd790608;
                c.gain  = 26'd40506324;
            end
            4'd2:
            begin
                c.home  = HALF_PI_Q24;
                c.shift = 26'd12386187;
                c.gain  = 26'd28381982;
                c.nudge = 7'd90;
            end
            4'd3:
            begin
                c.shift = 26'd39530384;
                c.gain  = 26'd27814342;
                c.nudge = 7'd20;
            end
            4'd4:
            begin
                c.nudge = 7'd60;
            end
            4'd5:
            begin
                c.nudge = 7'd25;
            end
            default:
            begin
                c.nudge = 7'd0;
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/ssrp_in_if.sv]
// Request channel: kind, seven targets and elapsed time.
interface ssrp_in_if import ssrp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TARGET_W-1:0]  target_0;
    logic [TARGET_W-1:0]  target_1;
    logic [TARGET_W-1:0]  target_2;
    logic [TARGET_W-1:0]  target_3;
    logic [TARGET_W-1:0]  target_4;
    logic [TARGET_W-1:0]  target_5;
    logic [TARGET_W-1:0]  target_6;
    logic [ELAPSED_W-1:0] tick_us;

    modport source (output valid, kind, target_0, target_1, target_2, target_3, target_4,
                    target_5, target_6, tick_us, input ready);
    modport sink (input valid, kind, target_0, target_1, target_2, target_3, target_4,
                  target_5, target_6, tick_us, output ready);
endinterface

[rtl/ssrp_out_if.sv]
// Result channel: seven pulse widths.
interface ssrp_out_if import ssrp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_0;
    logic [PULSE_W-1:0] pulse_1;
    logic [PULSE_W-1:0] pulse_2;
    logic [PULSE_W-1:0] pulse_3;
    logic [PULSE_W-1:0] pulse_4;
    logic [PULSE_W-1:0] pulse_5;
    logic [PULSE_W-1:0] pulse_6;

    modport source (output valid, pulse_0, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
                    pulse_6, input ready);
    modport sink (input valid, pulse_0, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
                  pulse_6, output ready);
endinterface

[rtl/ssrp_cfg.sv]
// APB register file: inverse command period and speed limit.
module ssrp_cfg import ssrp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [INV_W-1:0]    inv_reg;
    logic [INV_W-1:0]    inv_next;
    logic [MAXSPD_W-1:0] max_reg;
    logic [MAXSPD_W-1:0] max_next;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1];

    always_comb
    begin
        inv_next = inv_reg;
        max_next = max_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_INVERSE_PERIOD: inv_next = pwdata[INV_W-1:0];
                REG_MAX_SPEED:      max_next = pwdata[MAXSPD_W-1:0];
                default:            inv_next = inv_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INVERSE_PERIOD: prdata = DATA_W'(inv_reg);
            REG_MAX_SPEED:      prdata = DATA_W'(max_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= INV_PERIOD_RST;
            max_reg <= MAX_SPEED_RST;
        end
        else
        begin
            inv_reg <= inv_next;
            max_reg <= max_next;
        end
    end

    assign cfg.inverse_period = inv_reg;
    assign cfg.max_speed      = max_reg;

endmodule

[rtl/ssrp_lane.sv]
// One joint: holds angle, target and speed, steps them and maps the angle to a pulse.
module ssrp_lane import ssrp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  lane_const_t lconst,
    input  lane_cmd_t   cmd,
    input  logic        take,
    output lane_stat_t  stat
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SET_MUL   = 4'd1;
    localparam logic [3:0] ST_SET_CLAMP = 4'd2;
    localparam logic [3:0] ST_TICK_MUL  = 4'd3;
    localparam logic [3:0] ST_TICK_REC  = 4'd4;
    localparam logic [3:0] ST_TICK_QUOT = 4'd5;
    localparam logic [3:0] ST_TICK_MOVE = 4'd6;
    localparam logic [3:0] ST_PULSE_MUL = 4'd7;
    localparam logic [3:0] ST_PULSE_FIN = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    logic [3:0]                  state_reg, state_next;
    logic signed [ANGLE_W-1:0]   angle_reg, angle_next;
    logic signed [ANGLE_W-1:0]   target_reg, target_next;
    logic signed [ANGLE_W-1:0]   speed_reg, speed_next;

    logic signed [TARGET_W-1:0]  tgt_in_reg, tgt_in_next;
    logic [ELAPSED_W-1:0]        elapsed_reg, elapsed_next;
    logic signed [49:0]          prod_reg, prod_next;
    logic [54:0]                 rec_lo_reg, rec_lo_next;
    logic [54:0]                 rec_hi_reg, rec_hi_next;
    logic                        neg_reg, neg_next;
    logic [29:0]                 quot_reg, quot_next;
    logic signed [59:0]          pprod_reg, pprod_next;
    logic [PULSE_W-1:0]          pulse_reg, pulse_next;

    logic signed [32:0]          diff_s;
    logic signed [49:0]          set_prod;
    logic signed [47:0]          tick_prod;
    logic signed [41:0]          spd_full;
    logic signed [41:0]          max_pos;
    logic signed [41:0]          max_neg;
    logic signed [ANGLE_W-1:0]   spd_clamped;
    logic [46:0]                 tick_mag;
    logic [35:0]                 tick_q;
    logic [72:0]                 quot_sum;
    logic signed [30:0]          delta;
    logic signed [32:0]          move_sum;
    logic signed [ANGLE_W-1:0]   moved;
    logic                        pin;
    logic signed [32:0]          pulse_arg;
    logic signed [20:0]          pulse_val;

    // Set-targets speed: floor((target - angle) * inverse_period / 256), clamped
    assign diff_s   = 33'($signed(tgt_in_reg)) - 33'(angle_reg);
    assign set_prod = 50'(diff_s) * 50'($signed({1'b0, cfg.inverse_period}));
    assign spd_full = prod_reg[49:8];
    assign max_pos  = $signed(42'(cfg.max_speed));
    assign max_neg  = -max_pos;

    always_comb
    begin
        priority if (spd_full > max_pos)
            spd_clamped = max_pos[ANGLE_W-1:0];
        else if (spd_full < max_neg)
            spd_clamped = max_neg[ANGLE_W-1:0];
        else
            spd_clamped = spd_full[ANGLE_W-1:0];
    end

    // Tick: |speed * elapsed| / 256000 as (>> 11) then reciprocal of 125
    assign tick_prod = 48'(speed_reg) * 48'($signed({1'b0, elapsed_reg}));
    assign tick_mag  = prod_reg[49] ? 47'(-prod_reg) : prod_reg[46:0];
    assign tick_q    = tick_mag[46:11];
    assign quot_sum  = {rec_hi_reg, 18'd0} + 73'(rec_lo_reg);
    assign delta     = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
    assign move_sum  = 33'(angle_reg) + 33'(delta);

    always_comb
    begin
        priority if (move_sum[32] != move_sum[31])
            moved = move_sum[32] ? ANGLE_MIN : ANGLE_MAX;
        else
            moved = move_sum[ANGLE_W-1:0];
    end

    // Pin a joint that overshoots its target
    assign pin = ((speed_reg > 0) && (moved > target_reg)) ||
                 ((speed_reg < 0) && (moved < target_reg));

    assign pulse_arg = 33'(angle_reg) + 33'($signed({1'b0, lconst.shift}));
    assign pulse_val = 21'($signed(pprod_reg[59:40])) +
                       21'($signed({1'b0, PULSE_BASE})) +
                       21'($signed({1'b0, lconst.nudge}));

    always_comb
    begin
        state_next   = state_reg;
        angle_next   = angle_reg;
        target_next  = target_reg;
        speed_next   = speed_reg;
        tgt_in_next  = tgt_in_reg;
        elapsed_next = elapsed_reg;
        prod_next    = prod_reg;
        rec_lo_next  = rec_lo_reg;
        rec_hi_next  = rec_hi_reg;
        neg_next     = neg_reg;
        quot_next    = quot_reg;
        pprod_next   = pprod_reg;
        pulse_next   = pulse_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    tgt_in_next  = cmd.target;
                    elapsed_next = cmd.elapsed;
                    unique case (cmd.kind)
                        KIND_SET:  state_next = ST_SET_MUL;
                        KIND_TICK: state_next = ST_TICK_MUL;
                        KIND_HOME:
                        begin
                            angle_next  = lconst.home;
                            target_next = lconst.home;
                            speed_next  = '0;
                            state_next  = ST_PULSE_MUL;
                        end
                        default:   state_next = ST_PULSE_MUL;
                    endcase
                end
            end
            ST_SET_MUL:
            begin
                prod_next  = set_prod;
                state_next = ST_SET_CLAMP;
            end
            ST_SET_CLAMP:
            begin
                speed_next  = spd_clamped;
                target_next = 32'($signed(tgt_in_reg));
                state_next  = ST_PULSE_MUL;
            end
            ST_TICK_MUL:
            begin
                prod_next  = 50'(tick_prod);
                state_next = ST_TICK_REC;
            end
            ST_TICK_REC:
            begin
                rec_lo_next = 55'(tick_q[17:0]) * 55'(RECIP_125);
                rec_hi_next = 55'(tick_q[35:18]) * 55'(RECIP_125);
                neg_next    = prod_reg[49];
                state_next  = ST_TICK_QUOT;
            end
            ST_TICK_QUOT:
            begin
                quot_next  = quot_sum[72:43];
                state_next = ST_TICK_MOVE;
            end
            ST_TICK_MOVE:
            begin
                if (pin)
                begin
                    angle_next = target_reg;
                    speed_next = '0;
                end
                else
                begin
                    angle_next = moved;
                end
                state_next = ST_PULSE_MUL;
            end
            ST_PULSE_MUL:
            begin
                pprod_next = 60'(pulse_arg) * 60'($signed({1'b0, lconst.gain}));
                state_next = ST_PULSE_FIN;
            end
            ST_PULSE_FIN:
            begin
                priority if (pulse_val < 0)
                    pulse_next = '0;
                else if (pulse_val > $signed(21'(PULSE_MAX)))
                    pulse_next = PULSE_MAX;
                else
                    pulse_next = pulse_val[PULSE_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            angle_reg  <= lconst.home;
            target_reg <= lconst.home;
            speed_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            angle_reg  <= angle_next;
            target_reg <= target_next;
            speed_reg  <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_in_reg  <= tgt_in_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        rec_lo_reg  <= rec_lo_next;
        rec_hi_reg  <= rec_hi_next;
        neg_reg     <= neg_next;
        quot_reg    <= quot_next;
        pprod_reg   <= pprod_next;
        pulse_reg   <= pulse_next;
    end

    assign stat.done  = (state_reg == ST_DONE);
    assign stat.pulse = pulse_reg;

endmodule

[rtl/ssrp_merge.sv]
// Merge stage: gathers the lane pulses into the result register.
module ssrp_merge import ssrp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  lane_stat_t  lane_stat [JOINTS],
    output logic        take,
    ssrp_out_if.source  pwm
);

    logic               out_valid_reg, out_valid_next;
    logic [PULSE_W-1:0] pulse_reg [JOINTS];
    logic               all_done;

    always_comb
    begin
        all_done = 1'b1;
        for (int j = 0; j < JOINTS; j++)
        begin
            all_done = all_done && lane_stat[j].done;
        end
    end

    // Load when every lane is finished and the result slot is free or draining
    assign take = all_done && (!out_valid_reg || pwm.ready);

    always_comb
    begin
        priority if (take)
            out_valid_next = 1'b1;
        else if (pwm.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                pulse_reg[j] <= lane_stat[j].pulse;
            end
        end
    end

    assign pwm.valid   = out_valid_reg;
    assign pwm.pulse_0 = pulse_reg[0];
    assign pwm.pulse_1 = pulse_reg[1];
    assign pwm.pulse_2 = pulse_reg[2];
    assign pwm.pulse_3 = pulse_reg[3];
    assign pwm.pulse_4 = pulse_reg[4];
    assign pwm.pulse_5 = pulse_reg[5];
    assign pwm.pulse_6 = pulse_reg[6];

endmodule

[rtl/servo_slew_ramp_pulse_mapper.sv]
// Top level: seven-joint servo slew ramp with pulse-width mapping.
//
//  channel  dir  handshake        payload
//  cmd      in   valid / ready    kind, target_0..target_6, tick_us
//  pwm      out  valid / ready    pulse_0..pulse_6
//  apb      in   psel / penable   inverse_period (0x0), max_speed (0x4)
//
// Seven lanes, one per joint, step in lockstep through their multiplier chain.
// A tick passes the most lane states, set targets fewer, and home or an unused kind
// the fewest; the next request is taken the cycle after the result loads.
// Reset puts every joint at its home pose with zero speed and loads the
// register defaults. A stalled result holds in the output register while the
// next request is already being worked.
module servo_slew_ramp_pulse_mapper import ssrp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    ssrp_in_if.sink           cmd,
    ssrp_out_if.source        pwm
);

    cfg_t                cfg;
    logic                busy_reg, busy_next;
    logic                accept;
    logic                take;
    logic [TARGET_W-1:0] target_arr [JOINTS];
    lane_stat_t          lane_stat [JOINTS];

    ssrp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign cmd.ready = !busy_reg;
    assign accept    = cmd.valid && !busy_reg;

    // Hold off new requests until the lanes hand their pulses to the merge stage
    always_comb
    begin
        priority if (accept)
            busy_next = 1'b1;
        else if (take)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    assign target_arr[0] = cmd.target_0;
    assign target_arr[1] = cmd.target_1;
    assign target_arr[2] = cmd.target_2;
    assign target_arr[3] = cmd.target_3;
    assign target_arr[4] = cmd.target_4;
    assign target_arr[5] = cmd.target_5;
    assign target_arr[6] = cmd.target_6;

    for (genvar j = 0; j < JOINTS; j++)
    begin : g_lane
        lane_cmd_t lcmd;

        assign lcmd.start   = accept;
        assign lcmd.kind    = cmd.kind;
        assign lcmd.target  = target_arr[j];
        assign lcmd.elapsed = cmd.tick_us;

        ssrp_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cfg    (cfg),
            .lconst (lane_const_of(JOINT_IDX_W'(j))),
            .cmd    (lcmd),
            .take   (take),
            .stat   (lane_stat[j])
        );
    end

    ssrp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_stat (lane_stat),
        .take      (take),
        .pwm       (pwm)
    );

endmodule

[rtl/ssrp_checker.sv]
// Port-level checker for the servo slew ramp pulse mapper, bound to the top level.
module ssrp_checker import ssrp_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PULSE_W-1:0] pulse_0,
    input logic [PULSE_W-1:0] pulse_1,
    input logic [PULSE_W-1:0] pulse_2,
    input logic [PULSE_W-1:0] pulse_3,
    input logic [PULSE_W-1:0] pulse_4,
    input logic [PULSE_W-1:0] pulse_5,
    input logic [PULSE_W-1:0] pulse_6
);

    // Result must hold until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Only one request in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // A request cannot produce a result before the lanes finish
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Every pulse stays within the timer range
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_0 <= PULSE_MAX) && (pulse_1 <= PULSE_MAX) &&
                      (pulse_2 <= PULSE_MAX) && (pulse_3 <= PULSE_MAX) &&
                      (pulse_4 <= PULSE_MAX) && (pulse_5 <= PULSE_MAX) &&
                      (pulse_6 <= PULSE_MAX))
        else $error("pulse width out of range");

endmodule

bind servo_slew_ramp_pulse_mapper ssrp_checker u_ssrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (pwm.valid),
    .out_ready (pwm.ready),
    .pulse_0   (pwm.pulse_0),
    .pulse_1   (pwm.pulse_1),
    .pulse_2   (pwm.pulse_2),
    .pulse_3   (pwm.pulse_3),
    .pulse_4   (pwm.pulse_4),
    .pulse_5   (pwm.pulse_5),
    .pulse_6   (pwm.pulse_6)
);

[sim/servo_slew_ramp_pulse_mapper_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the servo ramp: mirrors joint state, predicts pulse widths and compares them.
module servo_slew_ramp_pulse_mapper_checker
    import ssrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    ssrp_in_if                cmd,
    ssrp_out_if               pwm,
    output int                errors,
    output int                pending
);

    typedef logic [JOINTS-1:0][PULSE_W-1:0]  pulse_set_t;
    typedef logic [JOINTS-1:0][TARGET_W-1:0] target_set_t;

    localparam longint TICK_DIV    = 256000;
    localparam longint BASE_COUNTS = 500;
    localparam longint TOP_COUNTS  = 19999;

    logic signed [ANGLE_W-1:0] angle [JOINTS];
    logic signed [ANGLE_W-1:0] aim [JOINTS];
    logic signed [ANGLE_W-1:0] rate [JOINTS];
    logic [INV_W-1:0]          inv_period;
    logic [MAXSPD_W-1:0]       speed_cap;
    pulse_set_t                pulse_queue [$];

    function automatic longint joint_shift(input int j);
        case (j)
            0: return 0;
            1: return 790608;
            2: return 12386187;
            3: return 39530384;
            default: return 26353589;
        endcase
    endfunction

    function automatic longint joint_gain(input int j);
        case (j)
            0: return 28381982;
            1: return 40506324;
            2: return 28381982;
            3: return 27814342;
            default: return 41721513;
        endcase
    endfunction

    function automatic longint joint_nudge(input int j);
        case (j)
            2: return 90;
            3: return 20;
            4: return 60;
            5: return 25;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [ANGLE_W-1:0] home_angle(input int j);
        return (j == 1 || j == 2) ? HALF_PI_Q24 : '0;
    endfunction

    task automatic move_home();
        for (int j = 0; j < JOINTS; j++)
        begin
            angle[j] = home_angle(j);
            aim[j]   = home_angle(j);
            rate[j]  = '0;
        end
    endtask

    task automatic apply_request(input logic [KIND_W-1:0] kind, input target_set_t tg,
                                 input logic [ELAPSED_W-1:0] el);
        longint                    t;
        longint                    s;
        longint                    d;
        longint                    sum;
        longint                    ip;
        longint                    cap;
        longint                    dt;
        logic signed [ANGLE_W-1:0] na;
        ip  = inv_period;
        cap = speed_cap;
        dt  = el;
        case (kind)
            KIND_SET:
            begin
                for (int j = 0; j < JOINTS; j++)
                begin
                    t = $signed(tg[j]);
                    // Q.40 product, floor to Q0.32
                    s = ((t - longint'(angle[j])) * ip) >>> 8;
                    if (s > cap)
                        s = cap;
                    if (s < -cap)
                        s = -cap;
                    aim[j]  = t[ANGLE_W-1:0];
                    rate[j] = s[ANGLE_W-1:0];
                end
            end
            KIND_TICK:
            begin
                for (int j = 0; j < JOINTS; j++)
                begin
                    d   = (longint'(rate[j]) * dt) / TICK_DIV;
                    sum = longint'(angle[j]) + d;
                    if (sum > longint'(ANGLE_MAX))
                        sum = longint'(ANGLE_MAX);
                    if (sum < longint'(ANGLE_MIN))
                        sum = longint'(ANGLE_MIN);
                    na = sum[ANGLE_W-1:0];
                    // pin a joint that ran past its target
                    if ((rate[j] > 0 && na > aim[j]) || (rate[j] < 0 && na < aim[j]))
                    begin
                        na      = aim[j];
                        rate[j] = '0;
                    end
                    angle[j] = na;
                end
            end
            KIND_HOME:
            begin
                move_home();
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic pulse_set_t current_pulses();
        longint     v;
        pulse_set_t p;
        for (int j = 0; j < JOINTS; j++)
        begin
            v = ((longint'(angle[j]) + joint_shift(j)) * joint_gain(j)) >>> 40;
            v = v + BASE_COUNTS + joint_nudge(j);
            if (v < 0)
                v = 0;
            if (v > TOP_COUNTS)
                v = TOP_COUNTS;
            p[j] = v[PULSE_W-1:0];
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_set_t  got;
        pulse_set_t  want;
        target_set_t tg;
        if (!rst_n)
        begin
            inv_period = INV_PERIOD_RST;
            speed_cap  = MAX_SPEED_RST;
            move_home();
            pulse_queue.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_INVERSE_PERIOD: inv_period = pwdata[INV_W-1:0];
                    REG_MAX_SPEED:      speed_cap  = pwdata[MAXSPD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                tg = {cmd.target_6, cmd.target_5, cmd.target_4, cmd.target_3,
                      cmd.target_2, cmd.target_1, cmd.target_0};
                apply_request(cmd.kind, tg, cmd.tick_us);
                pulse_queue.push_back(current_pulses());
            end
            if (pwm.valid && pwm.ready)
            begin
                got = {pwm.pulse_6, pwm.pulse_5, pwm.pulse_4, pwm.pulse_3,
                       pwm.pulse_2, pwm.pulse_1, pwm.pulse_0};
                if (pulse_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request waiting, expected none got %h",
                             $time, got);
                end
                else
                begin
                    want = pulse_queue.pop_front();
                    for (int j = 0; j < JOINTS; j++)
                    begin
                        if (got[j] !== want[j])
                        begin
                            errors++;
                            $display("%0t: pulse_%0d expected %0d got %0d",
                                     $time, j, want[j], got[j]);
                        end
                    end
                end
            end
            pending = pulse_queue.size();
        end
    end

endmodule

[sim/servo_slew_ramp_pulse_mapper_tb.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and register stimulus, watchdog and verdict.
module servo_slew_ramp_pulse_mapper_tb;
    import ssrp_pkg::*;

    typedef logic [JOINTS-1:0][TARGET_W-1:0] target_set_t;

    localparam logic [KIND_W-1:0]   KIND_SPARE     = 2'd3;
    localparam logic [TARGET_W-1:0] TARGET_MAX     = 28'h7FFFFFF;
    localparam logic [TARGET_W-1:0] TARGET_MIN     = 28'h8000000;
    localparam int                  WATCHDOG_LIMIT = 5000;
    localparam int                  PHASE_ITEMS    = 310;
    localparam int                  DRAIN_CYCLES   = 12;
    localparam int                  HOLD_START     = 2500;
    localparam int                  HOLD_CYCLES    = 300;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                idle_cycles;
    int                sink_cycle;
    int                stall_left;
    bit                src_gaps;
    bit                sink_gaps;

    ssrp_in_if  cmd_ch ();
    ssrp_out_if pwm_ch ();

    servo_slew_ramp_pulse_mapper dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .pwm     (pwm_ch)
    );

    servo_slew_ramp_pulse_mapper_checker pulse_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .pwm     (pwm_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: random stall bursts plus one long hold to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            sink_cycle++;
            if (sink_cycle == HOLD_START)
                stall_left = HOLD_CYCLES;
            if (stall_left > 0)
            begin
                pwm_ch.ready = 1'b0;
                stall_left--;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                pwm_ch.ready = 1'b0;
                stall_left   = $urandom_range(0, 10);
            end
            else
            begin
                pwm_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (pwm_ch.valid && pwm_ch.ready)
                || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [TARGET_W-1:0] rand_target();
        if ($urandom_range(0, 7) == 0)
            return TARGET_W'($urandom);
        return TARGET_W'(int'($urandom_range(0, 67108864)) - 33554432);
    endfunction

    function automatic target_set_t random_targets();
        target_set_t tg;
        for (int j = 0; j < JOINTS; j++)
            tg[j] = rand_target();
        return tg;
    endfunction

    function automatic target_set_t uniform(input logic [TARGET_W-1:0] value);
        target_set_t tg;
        for (int j = 0; j < JOINTS; j++)
            tg[j] = value;
        return tg;
    endfunction

    function automatic logic [ELAPSED_W-1:0] rand_elapsed();
        if ($urandom_range(0, 3) == 0)
            return ELAPSED_W'($urandom);
        return ELAPSED_W'($urandom_range(0, 4000));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input target_set_t tg,
                                input logic [ELAPSED_W-1:0] el);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        cmd_ch.valid    = 1'b1;
        cmd_ch.kind     = kind;
        cmd_ch.target_0 = tg[0];
        cmd_ch.target_1 = tg[1];
        cmd_ch.target_2 = tg[2];
        cmd_ch.target_3 = tg[3];
        cmd_ch.target_4 = tg[4];
        cmd_ch.target_5 = tg[5];
        cmd_ch.target_6 = tg[6];
        cmd_ch.tick_us  = el;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic random_request();
        int                r;
        logic [KIND_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 22)
            k = KIND_SET;
        else if (r < 88)
            k = KIND_TICK;
        else if (r < 94)
            k = KIND_HOME;
        else
            k = KIND_SPARE;
        send_request(k, random_targets(), rand_elapsed());
    endtask

    // Drop valid, wait for every result, then let the pipeline go quiet
    task automatic settle();
        cmd_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [INV_W-1:0] ip, input logic [MAXSPD_W-1:0] ms);
        write_reg(REG_INVERSE_PERIOD, DATA_W'(ip));
        write_reg(REG_MAX_SPEED, DATA_W'(ms));
    endtask

    initial
    begin
        target_set_t home_pose;
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.kind     = KIND_SET;
        cmd_ch.target_0 = '0;
        cmd_ch.target_1 = '0;
        cmd_ch.target_2 = '0;
        cmd_ch.target_3 = '0;
        cmd_ch.target_4 = '0;
        cmd_ch.target_5 = '0;
        cmd_ch.target_6 = '0;
        cmd_ch.tick_us  = '0;
        pwm_ch.ready    = 1'b0;
        src_gaps        = 1'b1;
        sink_gaps       = 1'b1;
        sink_cycle      = 0;
        stall_left      = 0;
        home_pose       = '0;
        home_pose[1]    = TARGET_W'(HALF_PI_Q24);
        home_pose[2]    = TARGET_W'(HALF_PI_Q24);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: unused kind, full-scale targets, long and zero ticks, home
        send_request(KIND_SPARE, random_targets(), 16'hFFFF);
        send_request(KIND_SET, uniform(TARGET_MAX), 16'd0);
        send_request(KIND_TICK, random_targets(), 16'hFFFF);
        send_request(KIND_TICK, '0, 16'd0);
        send_request(KIND_TICK, random_targets(), 16'hFFFF);
        send_request(KIND_SET, uniform(TARGET_MIN), 16'hFFFF);
        repeat (3) send_request(KIND_TICK, random_targets(), 16'hFFFF);
        send_request(KIND_HOME, random_targets(), 16'hFFFF);
        send_request(KIND_SET, home_pose, 16'hFFFF);
        send_request(KIND_TICK, random_targets(), 16'hFFFF);
        send_request(KIND_SPARE, '0, 16'd0);
        settle();

        // Widest settings: speeds clamp at the top and joints overshoot into the pin
        set_config(16'hFFFF, 31'h7FFFFFFF);
        send_request(KIND_SET, uniform(TARGET_MIN), 16'd0);
        send_request(KIND_TICK, random_targets(), 16'hFFFF);
        send_request(KIND_SET, uniform(TARGET_MAX), 16'd0);
        send_request(KIND_TICK, random_targets(), 16'd1);
        send_request(KIND_TICK, random_targets(), 16'hFFFF);
        send_request(KIND_HOME, random_targets(), 16'd0);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: set_config(INV_PERIOD_RST, MAX_SPEED_RST);
                1: set_config(INV_W'($urandom), MAXSPD_W'($urandom));
                2: set_config(16'd0, MAXSPD_W'($urandom));
                3: set_config(INV_W'($urandom), 31'd0);
                4: set_config(INV_W'($urandom), MAXSPD_W'($urandom_range(0, 67108864)));
                default:
                begin
                    src_gaps  = 1'b0;
                    sink_gaps = 1'b0;
                    set_config(INV_PERIOD_RST, MAX_SPEED_RST);
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
        end
        settle();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/ssrp_pkg.sv
rtl/ssrp_in_if.sv
rtl/ssrp_out_if.sv
rtl/ssrp_cfg.sv
rtl/ssrp_lane.sv
rtl/ssrp_merge.sv
rtl/servo_slew_ramp_pulse_mapper.sv
rtl/ssrp_checker.sv
sim/servo_slew_ramp_pulse_mapper_checker.sv
sim/servo_slew_ramp_pulse_mapper_tb.sv
